>>> rtl/fvn_pkg.sv
// shared constants and register codes for the fractal value noise block
package fvn_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int COORD_W         = 32;
    localparam int NOISE_W         = FRAC_BITS + 1;
    localparam int AMP_W           = FRAC_BITS + 1;
    localparam int PERS_W          = 16;
    localparam int CNT_W           = 4;
    localparam int CNT_EFF_W       = 5;
    localparam int SUM_W           = FRAC_BITS + 5;
    localparam int DEF_MAX_OCTAVES = 8;

    localparam logic [AMP_W-1:0] ONE_Q = AMP_W'(1) << FRAC_BITS;

    // hash constants
    localparam logic [31:0] HASH_Y_MUL = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_M1    = 32'd15731;
    localparam logic [31:0] HASH_A1    = 32'd789221;
    localparam logic [31:0] HASH_A2    = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fffffff;

    // configuration register indexes
    localparam logic CFG_PERSISTENCE  = 1'b0;
    localparam logic CFG_OCTAVE_COUNT = 1'b1;

    localparam logic [PERS_W-1:0] PERS_RESET  = 16'd32768;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 4'd4;

endpackage

>>> rtl/fractal_value_noise_2d.sv
// top level: config registers, octave cell chain, divider and output skid stage
//
// One coordinate pair enters per clock and one noise sample leaves per clock
// while out_ready is high and the skid entry is empty. Each octave is a cell
// of 8 pipeline stages and the normalizing divider has 17 stages; every item
// passes through all MAX_OCTAVES cells whatever octave_count is set to, and
// the cells past octave_count pass their sums through unchanged. A two-entry
// output stage keeps in_ready registered. No clearing pass after reset.
module fractal_value_noise_2d
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [NOISE_W-1:0]        noise_value,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [PERS_W-1:0]         cfg_data
);

    localparam int XW    = COORD_W + MAX_OCTAVES - 1;
    localparam int LOG_N = $clog2(MAX_OCTAVES);
    localparam int TOT_W = SUM_W + AMP_W + LOG_N + 1;
    localparam int WGT_W = AMP_W + LOG_N + 1;
    localparam int DEN_W = WGT_W + 4;

    logic [PERS_W-1:0]    persistence_reg;
    logic [CNT_W-1:0]     octave_count_reg;
    logic [CNT_EFF_W-1:0] octave_num;

    logic                 cv [MAX_OCTAVES+1];
    logic signed [XW-1:0] cx [MAX_OCTAVES+1];
    logic signed [XW-1:0] cy [MAX_OCTAVES+1];
    logic [AMP_W-1:0]     ca [MAX_OCTAVES+1];
    logic [TOT_W-1:0]     ct [MAX_OCTAVES+1];
    logic [WGT_W-1:0]     cw [MAX_OCTAVES+1];

    logic                 advance;
    logic                 div_valid;
    logic [NOISE_W-1:0]   div_quot;

    logic                 out_valid_reg;
    logic [NOISE_W-1:0]   noise_value_reg;
    logic                 skid_valid_reg;
    logic [NOISE_W-1:0]   skid_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            persistence_reg  <= PERS_RESET;
            octave_count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PERSISTENCE:  persistence_reg  <= cfg_data;
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one octave, large counts saturate
    always_comb
    begin
        if (octave_count_reg == '0) begin
            octave_num = CNT_EFF_W'(1);
        end else if (CNT_EFF_W'(octave_count_reg) > CNT_EFF_W'(MAX_OCTAVES)) begin
            octave_num = CNT_EFF_W'(MAX_OCTAVES);
        end else begin
            octave_num = CNT_EFF_W'(octave_count_reg);
        end
    end

    assign advance  = !skid_valid_reg;
    assign in_ready = advance;

    assign cv[0] = in_valid;
    assign cx[0] = XW'(x_coord);
    assign cy[0] = XW'(y_coord);
    assign ca[0] = ONE_Q;
    assign ct[0] = '0;
    assign cw[0] = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
        fvn_cell #(
            .IDX   (i),
            .XW    (XW),
            .TOT_W (TOT_W),
            .WGT_W (WGT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (advance),
            .octave_num  (octave_num),
            .persistence (persistence_reg),
            .valid_in    (cv[i]),
            .x_in        (cx[i]),
            .y_in        (cy[i]),
            .amp_in      (ca[i]),
            .total_in    (ct[i]),
            .weight_in   (cw[i]),
            .valid_out   (cv[i+1]),
            .x_out       (cx[i+1]),
            .y_out       (cy[i+1]),
            .amp_out     (ca[i+1]),
            .total_out   (ct[i+1]),
            .weight_out  (cw[i+1])
        );
    end

    fvn_div #(
        .NUM_W (TOT_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (cv[MAX_OCTAVES]),
        .num       (ct[MAX_OCTAVES]),
        .den       ({cw[MAX_OCTAVES], 4'b0000}),
        .valid_out (div_valid),
        .quot      (div_quot)
    );

    // output register plus skid entry; pipeline freezes only while skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (div_valid) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                noise_value_reg <= skid_value_reg;
            end
        end else if (div_valid) begin
            if (out_valid_reg && !out_ready) begin
                skid_value_reg <= div_quot;
            end else begin
                noise_value_reg <= div_quot;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (noise_value_reg <= NOISE_W'(ONE_Q)))
        else $error("noise sample above one");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && div_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("finished sample dropped while output stalled");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");

endmodule

>>> rtl/fvn_cell.sv
// one octave cell: lattice hashing, 3x3 blend and weighted accumulation
module fvn_cell
    import fvn_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int XW    = 39,
    parameter int TOT_W = 41,
    parameter int WGT_W = 21
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [CNT_EFF_W-1:0]    octave_num,
    input  logic [PERS_W-1:0]       persistence,
    input  logic                    valid_in,
    input  logic signed [XW-1:0]    x_in,
    input  logic signed [XW-1:0]    y_in,
    input  logic [AMP_W-1:0]        amp_in,
    input  logic [TOT_W-1:0]        total_in,
    input  logic [WGT_W-1:0]        weight_in,
    output logic                    valid_out,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic [AMP_W-1:0]        amp_out,
    output logic [TOT_W-1:0]        total_out,
    output logic [WGT_W-1:0]        weight_out
);

    localparam int OW     = XW + 2;
    localparam int NSTG   = 7;
    localparam int PROD_W = SUM_W + AMP_W;
    localparam int AP_W   = AMP_W + PERS_W;
    localparam logic signed [OW-1:0] STEP = OW'(ONE_Q);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [AMP_W-1:0]     amp;
        logic [TOT_W-1:0]     total;
        logic [WGT_W-1:0]     weight;
    } pass_t;

    pass_t             pass_reg [NSTG];
    logic [NSTG-1:0]   vld_reg;

    logic [31:0]       tx_reg [3];
    logic [31:0]       ty_reg [3];
    logic [31:0]       tx_next [3];
    logic [31:0]       ty_next [3];
    logic [31:0]       n_reg [9];
    logic [31:0]       n_next [9];
    logic [31:0]       sq_reg [9];
    logic [31:0]       n2_reg [9];
    logic [31:0]       t_reg [9];
    logic [31:0]       n3_reg [9];
    logic [AMP_W-1:0]  h_reg [9];
    logic [AMP_W-1:0]  h_next [9];
    logic [SUM_W-1:0]  s_reg;
    logic [SUM_W-1:0]  s_next;
    logic [PROD_W-1:0] prod_reg;

    logic              valid_out_reg;
    logic signed [XW-1:0] x_out_reg;
    logic signed [XW-1:0] y_out_reg;
    logic [AMP_W-1:0]  amp_out_reg;
    logic [TOT_W-1:0]  total_out_reg;
    logic [WGT_W-1:0]  weight_out_reg;

    logic              active;
    logic [AP_W-1:0]   amp_scaled;

    // truncate toward zero and wrap to 32 bits
    function automatic logic [31:0] trunc_int(input logic signed [OW-1:0] v);
        logic [OW-1:0] mag;
        logic [OW-1:0] sh;
        logic [31:0]   t;
        mag = v[OW-1] ? OW'(-v) : OW'(v);
        sh  = mag >> FRAC_BITS;
        t   = sh[31:0];
        return v[OW-1] ? 32'(-t) : t;
    endfunction

    assign active = (CNT_EFF_W'(IDX) < octave_num);

    always_comb
    begin
        logic signed [OW-1:0] xb;
        logic signed [OW-1:0] yb;
        xb = OW'(x_in);
        yb = OW'(y_in);
        tx_next[0] = trunc_int(xb - STEP);
        tx_next[1] = trunc_int(xb);
        tx_next[2] = trunc_int(xb + STEP);
        ty_next[0] = trunc_int(yb - STEP);
        ty_next[1] = trunc_int(yb);
        ty_next[2] = trunc_int(yb + STEP);
    end

    // index is 3*y_offset + x_offset
    always_comb
    begin
        logic [31:0] nn;
        nn = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                nn = 32'(tx_reg[b] + ty_reg[a] * HASH_Y_MUL);
                n_next[a*3+b] = (nn << HASH_SHIFT) ^ nn;
            end
        end
    end

    always_comb
    begin
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < 9; k++) begin
            v = 32'(n3_reg[k] * t_reg[k] + HASH_A2) & HASH_MASK;
            h_next[k] = ONE_Q - AMP_W'(v[30:15]);
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] corners;
        logic [SUM_W-1:0] sides;
        corners = SUM_W'(h_reg[0]) + SUM_W'(h_reg[2]) + SUM_W'(h_reg[6]) + SUM_W'(h_reg[8]);
        sides   = SUM_W'(h_reg[1]) + SUM_W'(h_reg[3]) + SUM_W'(h_reg[5]) + SUM_W'(h_reg[7]);
        s_next  = corners + (sides << 1) + (SUM_W'(h_reg[4]) << 2);
    end

    assign amp_scaled = AP_W'(pass_reg[NSTG-1].amp) * AP_W'(persistence);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg       <= '0;
            valid_out_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[NSTG-2:0], valid_in};
            valid_out_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pass_reg[0] <= '{x: x_in, y: y_in, amp: amp_in, total: total_in, weight: weight_in};
            for (int k = 1; k < NSTG; k++) begin
                pass_reg[k] <= pass_reg[k-1];
            end
            for (int k = 0; k < 3; k++) begin
                tx_reg[k] <= tx_next[k];
                ty_reg[k] <= ty_next[k];
            end
            for (int k = 0; k < 9; k++) begin
                n_reg[k]  <= n_next[k];
                sq_reg[k] <= 32'(n_reg[k] * n_reg[k]);
                n2_reg[k] <= n_reg[k];
                t_reg[k]  <= 32'(sq_reg[k] * HASH_M1 + HASH_A1);
                n3_reg[k] <= n2_reg[k];
                h_reg[k]  <= h_next[k];
            end
            s_reg    <= s_next;
            prod_reg <= PROD_W'(s_reg) * PROD_W'(pass_reg[5].amp);
            x_out_reg   <= {pass_reg[NSTG-1].x[XW-2:0], 1'b0};
            y_out_reg   <= {pass_reg[NSTG-1].y[XW-2:0], 1'b0};
            amp_out_reg <= amp_scaled[AP_W-1:FRAC_BITS];
            if (active) begin
                total_out_reg  <= pass_reg[NSTG-1].total + TOT_W'(prod_reg);
                weight_out_reg <= pass_reg[NSTG-1].weight + WGT_W'(pass_reg[NSTG-1].amp);
            end else begin
                total_out_reg  <= pass_reg[NSTG-1].total;
                weight_out_reg <= pass_reg[NSTG-1].weight;
            end
        end
    end

    assign valid_out  = valid_out_reg;
    assign x_out      = x_out_reg;
    assign y_out      = y_out_reg;
    assign amp_out    = amp_out_reg;
    assign total_out  = total_out_reg;
    assign weight_out = weight_out_reg;

endmodule

>>> rtl/fvn_div.sv
// pipelined restoring divider, one quotient bit per stage
module fvn_div
    import fvn_pkg::*;
#(
    parameter int NUM_W = 41,
    parameter int DEN_W = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               valid_out,
    output logic [NOISE_W-1:0] quot
);

    localparam int Q_W = NOISE_W;
    localparam int CW  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]    r_reg [Q_W];
    logic [DEN_W-1:0] d_reg [Q_W];
    logic [Q_W-1:0]   q_reg [Q_W];
    logic [Q_W-1:0]   v_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [CW-1:0]    r_in;
        logic [DEN_W-1:0] d_in;
        logic [Q_W-1:0]   q_in;
        logic             v_in;
        logic [CW-1:0]    trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign r_in = CW'(num);
            assign d_in = den;
            assign q_in = '0;
            assign v_in = valid_in;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign q_in = q_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        assign trial = CW'(d_in) << (Q_W - 1 - k);
        assign ge    = (r_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                r_reg[k] <= ge ? r_in - trial : r_in;
                d_reg[k] <= d_in;
                q_reg[k] <= q_in | (Q_W'(ge) << (Q_W - 1 - k));
            end
        end
    end

    assign valid_out = v_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];

endmodule

>>> bench/tb_fractal_value_noise_2d.sv
// self-checking testbench for the fractal value noise block
module tb_fractal_value_noise_2d;
    import fvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DRAIN  = 120;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 400;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } coord_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      out_valid;
    logic                      out_ready;
    logic [NOISE_W-1:0]        noise_value;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [PERS_W-1:0]         cfg_data;

    coord_t             coord_queue[$];
    logic [NOISE_W-1:0] noise_expected[$];
    logic [PERS_W-1:0]  model_persistence;
    logic [CNT_W-1:0]   model_octaves;
    int                 error_count;
    int                 cycle_count;
    int                 accepted_count;
    bit                 in_taken;
    bit                 out_taken;
    bit                 calm;
    bit                 stall_done;
    int                 send_gap;
    int                 recv_gap;
    int                 stall_left;

    fractal_value_noise_2d u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .noise_value(noise_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // truncate Q.16 toward zero, wrap to 32 bits
    function automatic logic [31:0] grid_index(longint v);
        longint t;
        if (v < 0)
            t = -((-v) >> FRAC_BITS);
        else
            t = v >> FRAC_BITS;
        return t[31:0];
    endfunction

    function automatic longint lattice_value(longint x, longint y);
        logic [31:0] n;
        logic [31:0] h;
        n = grid_index(x) + grid_index(y) * HASH_Y_MUL;
        n = (n << HASH_SHIFT) ^ n;
        h = (n * (n * n * HASH_M1 + HASH_A1) + HASH_A2) & HASH_MASK;
        return longint'(65536) - longint'(h >> 15);
    endfunction

    function automatic longint octave_blend(longint x, longint y);
        longint d;
        longint corners;
        longint sides;
        d = longint'(1) << FRAC_BITS;
        corners = lattice_value(x - d, y - d) + lattice_value(x + d, y - d)
                + lattice_value(x - d, y + d) + lattice_value(x + d, y + d);
        sides = lattice_value(x - d, y) + lattice_value(x + d, y)
              + lattice_value(x, y - d) + lattice_value(x, y + d);
        return corners + 2 * sides + 4 * lattice_value(x, y);
    endfunction

    function automatic logic [NOISE_W-1:0] fractal_noise(coord_t c);
        int     count;
        longint amp;
        longint total;
        longint weight;
        longint xs;
        longint ys;
        longint quotient;
        count = model_octaves;
        if (count == 0)
            count = 1;
        if (count > DEF_MAX_OCTAVES)
            count = DEF_MAX_OCTAVES;
        amp = 65536;
        total = 0;
        weight = 0;
        for (int i = 0; i < count; i++)
        begin
            xs = longint'(c.x) <<< i;
            ys = longint'(c.y) <<< i;
            total += octave_blend(xs, ys) * amp;
            weight += amp;
            amp = (amp * model_persistence) >> 16;
        end
        quotient = total / (weight * 16);
        return quotient[NOISE_W-1:0];
    endfunction

    // monitor: record handshakes, predict on input, check on output
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready && rst_n;
        out_taken = out_valid && out_ready && rst_n;
        if (in_taken)
        begin
            noise_expected.push_back(fractal_noise('{x: x_coord, y: y_coord}));
            accepted_count++;
        end
        if (out_taken)
        begin
            if (noise_expected.size() == 0)
            begin
                $error("noise_value: unexpected transaction, actual %0d", noise_value);
                error_count++;
            end
            else
            begin
                if (noise_value !== noise_expected[0])
                begin
                    $error("noise_value: expected %0d, actual %0d",
                           noise_expected[0], noise_value);
                    error_count++;
                end
                void'(noise_expected.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        coord_t next_item;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (coord_queue.size() > 0)
            begin
                next_item = coord_queue.pop_front();
                x_coord <= next_item.x;
                y_coord <= next_item.y;
                in_valid <= 1'b1;
                send_gap = calm ? 0 : $urandom_range(0, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output receiver with one long hold-off while the driver keeps offering input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                recv_gap = calm ? 0 : $urandom_range(0, 6);
            if (!stall_done && accepted_count >= 300)
            begin
                stall_done = 1'b1;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic index, logic [PERS_W-1:0] value);
        @(negedge clk);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_PERSISTENCE)
            model_persistence = value;
        else
            model_octaves = value[CNT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        wait (coord_queue.size() == 0 && !in_valid && noise_expected.size() == 0);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic push_random(int count);
        coord_t c;
        for (int i = 0; i < count; i++)
        begin
            c.x = $urandom;
            c.y = $urandom;
            // mostly full-range coordinates, some near the origin
            if ($urandom_range(0, 3) == 0)
            begin
                c.x = $signed(c.x) >>> $urandom_range(8, 24);
                c.y = $signed(c.y) >>> $urandom_range(8, 24);
            end
            coord_queue.push_back(c);
        end
    endtask

    task automatic run_phase(logic [PERS_W-1:0] pers, logic [CNT_W-1:0] octaves,
                             int count, bit no_idle);
        write_reg(CFG_PERSISTENCE, pers);
        write_reg(CFG_OCTAVE_COUNT, {{(PERS_W-CNT_W){1'b0}}, octaves});
        calm = no_idle;
        push_random(count);
        drain_pipeline();
    endtask

    initial
    begin
        int xs[] = '{0, 32'h7fffffff, 32'h80000000, 32'h80000000, -1, 32'h0000ffff,
                     -65535, -65536, 65536, 32'h00010000, 32'h7fff0000, 32'h80010000};
        int ys[] = '{0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, -65535,
                     32'h0000ffff, 65536, -65536, -1, 32'h80000000, 32'h7fffffff};
        error_count = 0;
        cycle_count = 0;
        accepted_count = 0;
        calm = 1'b0;
        stall_done = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        stall_left = 0;
        model_persistence = PERS_RESET;
        model_octaves = COUNT_RESET;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PERSISTENCE;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners at reset settings
        for (int i = 0; i < xs.size(); i++)
            coord_queue.push_back('{x: xs[i], y: ys[i]});
        drain_pipeline();

        run_phase(16'd0, 4'd1, 6, 1'b0);
        run_phase(16'hffff, 4'd8, 6, 1'b0);
        run_phase(16'd0, 4'd0, 4, 1'b0);
        run_phase(16'h8000, 4'd15, 4, 1'b1);

        run_phase(16'h8000, 4'd4, 450, 1'b0);
        run_phase(16'hffff, 4'd8, 200, 1'b1);
        run_phase(16'd0, 4'd1, 150, 1'b0);
        for (int p = 0; p < 5; p++)
            run_phase(PERS_W'($urandom), CNT_W'($urandom), 90, p[0]);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
